// ===== design/hkrb_pkg.sv =====
`timescale 1ns / 1ps

package hkrb_pkg;

   localparam int SLOT_COUNT_DEFAULT  = 6;
   localparam int QUEUE_DEPTH_DEFAULT = 2;
   localparam int REPORT_SLOTS        = 6;
   localparam int SHIFT_FLAG_BIT      = 12;

   localparam logic [15:0] MEDIA_FIRST = 16'd8193;
   localparam logic [15:0] MEDIA_LAST  = 16'd8200;
   localparam logic [15:0] MOD_FIRST   = 16'd224;
   localparam logic [15:0] MOD_LAST    = 16'd231;
   localparam logic [7:0]  LEFT_SHIFT  = 8'h02;
   localparam logic [7:0]  LOW_BYTE    = 8'hFF;

   localparam logic [1:0] OP_PRESS       = 2'd0;
   localparam logic [1:0] OP_RELEASE     = 2'd1;
   localparam logic [1:0] OP_RELEASE_ALL = 2'd2;
   localparam logic [1:0] OP_UNUSED      = 2'd3;

   typedef enum logic [1:0] {
      KIND_KEYBOARD = 2'd0,
      KIND_MEDIA    = 2'd1,
      KIND_REJECT   = 2'd2,
      KIND_SUPPRESS = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ACT_PRESS   = 2'd0,
      ACT_RELEASE = 2'd1,
      ACT_CLEAR   = 2'd2
   } action_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [15:0] key_code;
   } req_type;

   typedef struct packed {
      kind_type   report_kind;
      logic [7:0] modifier_byte;
      logic [7:0] slot0;
      logic [7:0] slot1;
      logic [7:0] slot2;
      logic [7:0] slot3;
      logic [7:0] slot4;
      logic [7:0] slot5;
      logic [7:0] media_byte;
      logic       last_of_run;
   } rsp_type;

   // classified event handed from front to back
   typedef struct packed {
      action_type action;
      logic       is_media;
      logic [7:0] bits;
      logic [7:0] key;
      logic       wide;
   } cmd_type;

endpackage

// ===== design/hkrb_front.sv =====
`timescale 1ns / 1ps

module hkrb_front
   import hkrb_pkg::*;
(
   input  logic    start,
   input  logic    busy,
   input  req_type req_item,
   output logic    push,
   output cmd_type push_cmd
);

   logic [15:0] media_off;
   logic [15:0] code;
   logic [15:0] mod_off;
   logic        shift_flag;
   logic        is_mod;

   always_comb begin
      media_off  = req_item.key_code - MEDIA_FIRST;
      shift_flag = req_item.key_code[SHIFT_FLAG_BIT];
      code       = shift_flag ? {8'h00, req_item.key_code[7:0] & LOW_BYTE} : req_item.key_code;
      mod_off    = code - MOD_FIRST;
      is_mod     = (code >= MOD_FIRST) && (code <= MOD_LAST);

      push_cmd.is_media = (req_item.key_code >= MEDIA_FIRST) && (req_item.key_code <= MEDIA_LAST);
      case (req_item.op)
         OP_PRESS:       push_cmd.action = ACT_PRESS;
         OP_RELEASE:     push_cmd.action = ACT_RELEASE;
         OP_RELEASE_ALL: push_cmd.action = ACT_CLEAR;
         default:        push_cmd.action = ACT_CLEAR;
      endcase

      if (push_cmd.is_media) begin
         push_cmd.bits = 8'h01 << media_off[2:0];
         push_cmd.key  = 8'h00;
         push_cmd.wide = 1'b0;
      end else begin
         push_cmd.bits = (shift_flag ? LEFT_SHIFT : 8'h00)
                       | (is_mod ? (8'h01 << mod_off[2:0]) : 8'h00);
         // modifier codes collapse to key 0
         push_cmd.key  = is_mod ? 8'h00 : code[7:0];
         push_cmd.wide = !is_mod && (code[15:8] != 8'h00);
      end

      // unused op is dropped here and never queued
      push = start && !busy && (req_item.op != OP_UNUSED);
   end

endmodule

// ===== design/hkrb_queue.sv =====
`timescale 1ns / 1ps

module hkrb_queue
   import hkrb_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output logic    pop_valid,
   output cmd_type pop_cmd,
   output logic    full
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   cmd_type          entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_pop;

   assign full      = (count_ff == CNT_FULL);
   assign pop_valid = (count_ff != '0);
   assign pop_cmd   = entry_ff[rd_ptr_ff];
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== design/hkrb_back.sv =====
`timescale 1ns / 1ps

module hkrb_back
   import hkrb_pkg::*;
#(
   parameter int SLOT_COUNT = SLOT_COUNT_DEFAULT
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    csr_write,
   input  logic    csr_link,
   input  logic    cmd_valid,
   input  cmd_type cmd,
   output logic    cmd_ready,
   output logic    rsp_valid,
   output rsp_type rsp_item
);

   logic [7:0] slots_ff [SLOT_COUNT];
   logic [7:0] slots_in [SLOT_COUNT];
   logic [7:0] mod_ff, mod_in;
   logic [7:0] media_ff, media_in;
   logic       pend_ff, pend_in;
   logic       link_ff, link_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff, rsp_in;

   logic       fire;
   logic       last;
   kind_type   kind;
   logic       match;
   logic       found;
   logic [SLOT_COUNT-1:0] place;
   logic [7:0] view [REPORT_SLOTS];

   assign cmd_ready = !pend_ff;
   assign link_in   = csr_write ? csr_link : link_ff;

   always_comb begin
      match = 1'b0;
      found = 1'b0;
      place = '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         if (!cmd.wide && slots_ff[i] == cmd.key) begin
            match = 1'b1;
         end
         if (!found && slots_ff[i] == 8'h00) begin
            place[i] = 1'b1;
            found    = 1'b1;
         end
      end
   end

   always_comb begin
      slots_in = slots_ff;
      mod_in   = mod_ff;
      media_in = media_ff;
      pend_in  = pend_ff;
      fire     = 1'b0;
      last     = 1'b1;
      kind     = KIND_KEYBOARD;
      if (pend_ff) begin
         // second beat of a release-all
         fire    = 1'b1;
         kind    = KIND_MEDIA;
         pend_in = 1'b0;
      end else if (cmd_valid) begin
         fire = 1'b1;
         case (cmd.action)
            ACT_CLEAR: begin
               for (int i = 0; i < SLOT_COUNT; i++) begin
                  slots_in[i] = 8'h00;
               end
               mod_in   = 8'h00;
               media_in = 8'h00;
               last     = 1'b0;
               pend_in  = 1'b1;
            end
            ACT_PRESS: begin
               if (cmd.is_media) begin
                  media_in = media_ff | cmd.bits;
                  kind     = KIND_MEDIA;
               end else begin
                  mod_in = mod_ff | cmd.bits;
                  if (!match) begin
                     if (found) begin
                        for (int i = 0; i < SLOT_COUNT; i++) begin
                           if (place[i]) begin
                              slots_in[i] = cmd.key;
                           end
                        end
                     end else begin
                        kind = KIND_REJECT;
                     end
                  end
               end
            end
            ACT_RELEASE: begin
               if (cmd.is_media) begin
                  media_in = media_ff & ~cmd.bits;
                  kind     = KIND_MEDIA;
               end else begin
                  mod_in = mod_ff & ~cmd.bits;
                  for (int i = 0; i < SLOT_COUNT; i++) begin
                     if (!cmd.wide && cmd.key != 8'h00 && slots_ff[i] == cmd.key) begin
                        slots_in[i] = 8'h00;
                     end
                  end
               end
            end
            default: begin
               fire = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      for (int j = 0; j < REPORT_SLOTS; j++) begin
         view[j] = 8'h00;
      end
      for (int i = 0; i < SLOT_COUNT; i++) begin
         if (i < REPORT_SLOTS) begin
            view[i] = slots_in[i];
         end
      end
      rsp_in.report_kind   = (kind != KIND_REJECT && !link_ff) ? KIND_SUPPRESS : kind;
      rsp_in.modifier_byte = mod_in;
      rsp_in.slot0         = view[0];
      rsp_in.slot1         = view[1];
      rsp_in.slot2         = view[2];
      rsp_in.slot3         = view[3];
      rsp_in.slot4         = view[4];
      rsp_in.slot5         = view[5];
      rsp_in.media_byte    = media_in;
      rsp_in.last_of_run   = last;
      rsp_valid_in         = fire;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOT_COUNT; i++) begin
            slots_ff[i] <= 8'h00;
         end
         mod_ff       <= 8'h00;
         media_ff     <= 8'h00;
         pend_ff      <= 1'b0;
         link_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         slots_ff     <= slots_in;
         mod_ff       <= mod_in;
         media_ff     <= media_in;
         pend_ff      <= pend_in;
         link_ff      <= link_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

// ===== design/hid_keyboard_report_builder.sv =====
`timescale 1ns / 1ps
// keyboard report builder: keeps a boot keyboard report and a media byte
// request channel: an event (op, key_code) is taken on a clock edge with start high
//   and busy low; busy rises only while the event queue is full
// result channel: rsp_valid marks each report beat for one cycle; the receiver cannot
//   stall it, so every beat must be captured when shown
// config: csr_data[0] sets link_up on a csr_valid beat; csr_ready is always high
// path: an accepted event is written into the queue; the back stage builds its report beat
//   from the queue head and registers it onto the ports, after any beats ahead of it
// throughput: one event per cycle for single-report events, held while a release-all
//   sends its second beat; release-all gives a keyboard beat, then a media beat, and an
//   unused op gives none; the report stage is the limit, the queue absorbs short bursts
// reset: clears the queue, the key slots, modifier and media bits and link_up

module hid_keyboard_report_builder
   import hkrb_pkg::*;
#(
   parameter int SLOT_COUNT  = SLOT_COUNT_DEFAULT,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_valid,
   output rsp_type rsp_item,
   input  logic    csr_valid,
   output logic    csr_ready,
   input  logic    csr_data
);

   logic    push;
   cmd_type push_cmd;
   logic    pop_valid;
   cmd_type pop_cmd;
   logic    pop_ready;

   assign csr_ready = 1'b1;

   hkrb_front u_front (
      .start    (start),
      .busy     (busy),
      .req_item (req_item),
      .push     (push),
      .push_cmd (push_cmd)
   );

   hkrb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .pop       (pop_ready),
      .pop_valid (pop_valid),
      .pop_cmd   (pop_cmd),
      .full      (busy)
   );

   hkrb_back #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid && csr_ready),
      .csr_link  (csr_data),
      .cmd_valid (pop_valid),
      .cmd       (pop_cmd),
      .cmd_ready (pop_ready),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule

// ===== design/hkrb_checker.sv =====
`timescale 1ns / 1ps

module hkrb_checker
   import hkrb_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp_item
);

   // nothing comes out or stays blocked right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !busy)
      else $error("output or busy active after reset");

   // a non-final beat is always followed by the final beat of the same event
   a_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.last_of_run |=> rsp_valid && rsp_item.last_of_run)
      else $error("release-all pair broken");

   // the first beat of a release-all carries cleared modifier and media bytes and cleared slot0 and slot5
   a_cleared: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.last_of_run |->
         rsp_item.modifier_byte == 8'h00 && rsp_item.media_byte == 8'h00 &&
         rsp_item.slot0 == 8'h00 && rsp_item.slot5 == 8'h00)
      else $error("release-all report not cleared");

   // media and reject beats are always the last of their event
   a_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_item.report_kind == KIND_MEDIA ||
                    rsp_item.report_kind == KIND_REJECT) |-> rsp_item.last_of_run)
      else $error("media or reject beat not final");

endmodule

bind hid_keyboard_report_builder hkrb_checker u_hkrb_checker (
   .clock     (clock),
   .reset     (reset),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item)
);
